[rtl/itmtpp_pkg.sv]
// ----------------------------------------------------------------------------
// itmtpp_pkg
// Types and constants shared by the ITM trace packet parser.
// ----------------------------------------------------------------------------
package itmtpp_pkg;

    // One trace port beat on the input channel
    typedef struct packed {
        logic [7:0] trace_byte;
        logic       resync;
    } itm_in_t;

    // Byte classification codes
    typedef enum logic [3:0] {
        CLS_DROP    = 4'd0,
        CLS_THDR    = 4'd1,
        CLS_TDATA   = 4'd2,
        CLS_SHDR    = 4'd3,
        CLS_PAYLOAD = 4'd4,
        CLS_TIME    = 4'd5,
        CLS_EXT     = 4'd6,
        CLS_CONT    = 4'd7,
        CLS_ERROR   = 4'd8
    } byte_class_t;

    // One result beat on the output channel
    typedef struct packed {
        logic        target_valid;
        logic [7:0]  target_byte;
        byte_class_t byte_class;
        logic        new_unknown_opcode;
        logic        new_unknown_source;
        logic [31:0] raw_byte_count;
        logic [31:0] target_data_count;
        logic [31:0] time_packet_count;
        logic [31:0] overflow_count;
        logic [31:0] error_count;
        logic [31:0] source_mask;
        logic        in_sync;
    } itm_out_t;

    // Parser states, one-hot
    typedef enum logic [7:0] {
        ST_UNSYNC = 8'b0000_0001,
        ST_IDLE   = 8'b0000_0010,
        ST_TARGET = 8'b0000_0100,
        ST_CONT   = 8'b0000_1000,
        ST_SKIP4  = 8'b0001_0000,
        ST_SKIP3  = 8'b0010_0000,
        ST_SKIP2  = 8'b0100_0000,
        ST_SKIP1  = 8'b1000_0000
    } parse_state_t;

    // Header byte values and masks
    localparam logic [7:0] HDR_TARGET    = 8'h01;
    localparam logic [7:0] HDR_OVERFLOW  = 8'h70;
    localparam logic [7:0] LTS_LOW_MASK  = 8'h0f;
    localparam logic [7:0] LTS_HIGH_MASK = 8'h70;
    localparam logic [7:0] GTS_MASK      = 8'hdf;
    localparam logic [7:0] GTS_VALUE     = 8'h94;
    localparam logic [7:0] EXT_MASK      = 8'h0b;
    localparam logic [7:0] EXT_VALUE     = 8'h08;
    localparam logic [7:0] SIZE_MASK     = 8'h03;
    localparam logic [7:0] SW_HW_BIT     = 8'h04;
    localparam logic [7:0] CONT_BIT      = 8'h80;

    localparam logic [1:0] SIZE_ONE = 2'd1;
    localparam logic [1:0] SIZE_TWO = 2'd2;

    // Decoder verdict for one byte
    typedef struct packed {
        parse_state_t next_state;
        byte_class_t  byte_class;
        logic         target_data;
        logic         sw_source;
        logic         time_hdr;
        logic         error_hdr;
        logic         overflow;
    } itm_dec_t;

endpackage

[rtl/itmtpp_decode.sv]
// ----------------------------------------------------------------------------
// itmtpp_decode
// Classifies one trace byte against the current parser state and picks the
// next state.
// ----------------------------------------------------------------------------
module itmtpp_decode
    import itmtpp_pkg::*;
(
    input  logic [7:0]   trace_byte,
    input  logic         resync,
    input  parse_state_t state,
    output itm_dec_t     dec
);

    logic         local_ts;
    logic         global_ts;
    logic         sync_hdr;
    parse_state_t eff_state;
    parse_state_t after_hdr;

    assign local_ts  = ((trace_byte & LTS_LOW_MASK) == 8'h00)
                    && ((trace_byte & LTS_HIGH_MASK) != 8'h00)
                    && (trace_byte != HDR_OVERFLOW);
    assign global_ts = (trace_byte & GTS_MASK) == GTS_VALUE;
    assign sync_hdr  = (trace_byte == HDR_TARGET) || local_ts || global_ts;
    assign after_hdr = ((trace_byte & CONT_BIT) != 8'h00) ? ST_CONT : ST_IDLE;

    // resync wins, then a sync header lifts the unsynced state to idle
    always_comb begin
        eff_state = resync ? ST_UNSYNC : state;
        if (eff_state == ST_UNSYNC && sync_hdr) begin
            eff_state = ST_IDLE;
        end
    end

    always_comb begin
        dec = '{next_state: ST_IDLE, byte_class: CLS_DROP, target_data: 1'b0,
                sw_source: 1'b0, time_hdr: 1'b0, error_hdr: 1'b0, overflow: 1'b0};
        unique case (eff_state)
            ST_UNSYNC: begin
                dec.next_state = ST_UNSYNC;
            end
            ST_IDLE: begin
                priority if (trace_byte == HDR_TARGET) begin
                    dec.byte_class = CLS_THDR;
                    dec.next_state = ST_TARGET;
                end else if ((trace_byte & SIZE_MASK) != 8'h00) begin
                    dec.byte_class = CLS_SHDR;
                    dec.sw_source  = (trace_byte & SW_HW_BIT) == 8'h00;
                    if (trace_byte[1:0] == SIZE_ONE) begin
                        dec.next_state = ST_SKIP1;
                    end else if (trace_byte[1:0] == SIZE_TWO) begin
                        dec.next_state = ST_SKIP2;
                    end else begin
                        dec.next_state = ST_SKIP4;
                    end
                end else if (local_ts || global_ts) begin
                    dec.byte_class = CLS_TIME;
                    dec.time_hdr   = 1'b1;
                    dec.next_state = after_hdr;
                end else if ((trace_byte & EXT_MASK) == EXT_VALUE) begin
                    dec.byte_class = CLS_EXT;
                    dec.next_state = after_hdr;
                end else begin
                    dec.byte_class = CLS_ERROR;
                    dec.error_hdr  = 1'b1;
                    dec.overflow   = trace_byte == HDR_OVERFLOW;
                    dec.next_state = after_hdr;
                end
            end
            ST_TARGET: begin
                dec.byte_class  = CLS_TDATA;
                dec.target_data = 1'b1;
            end
            ST_CONT: begin
                dec.byte_class = CLS_CONT;
                dec.next_state = after_hdr;
            end
            ST_SKIP4: begin
                dec.byte_class = CLS_PAYLOAD;
                dec.next_state = ST_SKIP3;
            end
            ST_SKIP3: begin
                dec.byte_class = CLS_PAYLOAD;
                dec.next_state = ST_SKIP2;
            end
            ST_SKIP2: begin
                dec.byte_class = CLS_PAYLOAD;
                dec.next_state = ST_SKIP1;
            end
            ST_SKIP1: begin
                dec.byte_class = CLS_PAYLOAD;
            end
            default: begin
                dec.next_state = ST_UNSYNC;
            end
        endcase
    end

endmodule

[rtl/itm_trace_packet_parser_unit.sv]
// ----------------------------------------------------------------------------
// itm_trace_packet_parser_unit
// ITM/SWO trace packet parser: one trace byte per beat in, one status and
// classification beat per byte out.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload                          | beats
//  --------+--------------------+----------------------------------+----------
//  input   | s_valid / s_ready  | s_data  (itm_in_t: byte, resync) | 1 per byte
//  result  | m_valid / m_ready  | m_data  (itm_out_t)              | 1 per byte
//
//  One byte per cycle unless the result channel stalls: state, counters,
//  source mask and opcode map update in one pass of logic between the input
//  register and the result register; each beat passes through both in turn.
//  A stalled result holds in the result register; the input register takes a
//  beat in that cycle only if it is empty, so nothing is dropped.
//  Reset (aresetn low, synchronous) clears counters and maps and drops sync.
//
module itm_trace_packet_parser_unit
    import itmtpp_pkg::*;
#(
    parameter int COUNTER_WIDTH = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  itm_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output itm_out_t m_data
);

    localparam int CW = COUNTER_WIDTH;

    // Input register
    logic    in_valid_reg, in_valid_next;
    itm_in_t in_reg;

    // Result register
    logic     out_valid_reg, out_valid_next;
    itm_out_t out_reg, out_next;

    // Parser state
    parse_state_t state_reg, state_next;
    logic [CW-1:0] raw_reg, raw_next;
    logic [CW-1:0] tdata_reg, tdata_next;
    logic [CW-1:0] time_reg, time_next;
    logic [CW-1:0] ovf_reg, ovf_next;
    logic [CW-1:0] err_reg, err_next;
    logic [31:0]   mask_reg, mask_next;
    logic [255:0]  seen_reg, seen_next;

    logic          advance;
    itm_dec_t      dec;
    logic [4:0]    src_addr;
    logic          new_src;
    logic          new_op;

    // Counters widened so the low 32 bits can be taken at any width
    logic [CW+31:0] raw_ext, tdata_ext, time_ext, ovf_ext, err_ext;

    // Move a beat out of the input register whenever the result slot frees
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign in_valid_next  = s_ready ? s_valid : in_valid_reg;
    assign out_valid_next = advance ? 1'b1 : (out_valid_reg && !m_ready);

    itmtpp_decode u_decode (
        .trace_byte (in_reg.trace_byte),
        .resync     (in_reg.resync),
        .state      (state_reg),
        .dec        (dec)
    );

    assign src_addr = in_reg.trace_byte[7:3];
    assign new_src  = dec.sw_source && !mask_reg[src_addr];
    assign new_op   = dec.error_hdr && !seen_reg[in_reg.trace_byte];

    // Next state, counters and maps; hold when no beat advances
    always_comb begin
        state_next = state_reg;
        raw_next   = raw_reg;
        tdata_next = tdata_reg;
        time_next  = time_reg;
        ovf_next   = ovf_reg;
        err_next   = err_reg;
        mask_next  = mask_reg;
        seen_next  = seen_reg;
        if (advance) begin
            state_next = dec.next_state;
            raw_next   = raw_reg + CW'(1);
            if (dec.target_data) begin
                tdata_next = tdata_reg + CW'(1);
            end
            if (dec.time_hdr) begin
                time_next = time_reg + CW'(1);
            end
            if (dec.overflow) begin
                ovf_next = ovf_reg + CW'(1);
            end
            if (dec.error_hdr) begin
                err_next = err_reg + CW'(1);
                seen_next[in_reg.trace_byte] = 1'b1;
            end
            if (dec.sw_source) begin
                mask_next[src_addr] = 1'b1;
            end
        end
    end

    assign raw_ext   = {32'd0, raw_next};
    assign tdata_ext = {32'd0, tdata_next};
    assign time_ext  = {32'd0, time_next};
    assign ovf_ext   = {32'd0, ovf_next};
    assign err_ext   = {32'd0, err_next};

    // Assemble the result beat from post-update values
    always_comb begin
        out_next.target_valid       = dec.target_data;
        out_next.target_byte        = dec.target_data ? in_reg.trace_byte : 8'h00;
        out_next.byte_class         = dec.byte_class;
        out_next.new_unknown_opcode = new_op;
        out_next.new_unknown_source = new_src;
        out_next.raw_byte_count     = raw_ext[31:0];
        out_next.target_data_count  = tdata_ext[31:0];
        out_next.time_packet_count  = time_ext[31:0];
        out_next.overflow_count     = ovf_ext[31:0];
        out_next.error_count        = err_ext[31:0];
        out_next.source_mask        = mask_next;
        out_next.in_sync            = dec.next_state != ST_UNSYNC;
    end

    // Control and parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_UNSYNC;
            raw_reg       <= '0;
            tdata_reg     <= '0;
            time_reg      <= '0;
            ovf_reg       <= '0;
            err_reg       <= '0;
            mask_reg      <= '0;
            seen_reg      <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            raw_reg       <= raw_next;
            tdata_reg     <= tdata_next;
            time_reg      <= time_next;
            ovf_reg       <= ovf_next;
            err_reg       <= err_next;
            mask_reg      <= mask_next;
            seen_reg      <= seen_next;
        end
    end

    // Payload registers: load on handshake, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

[verif/itm_trace_packet_parser_unit_test.sv]
// ----------------------------------------------------------------------------
// itm_trace_packet_parser_unit_test
// Self-checking bench for the ITM/SWO trace packet parser. Trace bytes go in
// through the input channel. A behavioral decoder inside the bench works out
// the status beat that each byte must produce. Each result beat is compared
// field by field against the oldest outstanding prediction. Directed byte
// sequences cover every header class and the sync corner cases. Random
// packet streams follow, under three flow-control regimes.
// ----------------------------------------------------------------------------
module itm_trace_packet_parser_unit_test;
    import itmtpp_pkg::*;

    // Give up when nothing moves on either channel for this many cycles
    localparam int STALL_LIMIT = 2000;
    // Settling time after the last result
    localparam int DRAIN_CYCLES = 10;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    itm_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    itm_out_t m_data;

    // Idle rates, in percent of cycles, for the sender and the receiver
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    int mismatches = 0;
    int parsed_beats = 0;
    int quiet_cycles = 0;

    // Status beats predicted but not yet seen on the result channel
    itm_out_t decoded_beats[$];

    // Decoder state mirrored in the bench
    parse_state_t parse_st = ST_UNSYNC;
    logic [31:0]  raw_cnt = '0;
    logic [31:0]  tdata_cnt = '0;
    logic [31:0]  ts_cnt = '0;
    logic [31:0]  ovf_cnt = '0;
    logic [31:0]  err_cnt = '0;
    logic [31:0]  src_seen = '0;
    logic [255:0] opcode_seen = '0;

    itm_trace_packet_parser_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Behavioral decoder
    // ------------------------------------------------------------------------

    // Local timestamp: low nibble clear, some of bits 6:4 set, never overflow
    function automatic bit is_local_ts(input logic [7:0] c);
        return (c & LTS_LOW_MASK) == 8'h00 && (c & LTS_HIGH_MASK) != 8'h00
            && c != HDR_OVERFLOW;
    endfunction

    function automatic bit is_global_ts(input logic [7:0] c);
        return (c & GTS_MASK) == GTS_VALUE;
    endfunction

    // A header with bit 7 set is followed by continuation bytes
    function automatic parse_state_t after_hdr(input logic [7:0] c);
        return ((c & CONT_BIT) != 8'h00) ? ST_CONT : ST_IDLE;
    endfunction

    // Advance the mirrored decoder by one trace byte and return its status beat
    function automatic itm_out_t decode_trace_byte(input logic [7:0] c, input logic rs);
        itm_out_t     r;
        parse_state_t st;
        parse_state_t nxt;
        logic [31:0]  src_bit;
        r = '0;
        nxt = ST_IDLE;
        st = rs ? ST_UNSYNC : parse_st;
        raw_cnt = raw_cnt + 32'd1;
        // Only a target header or a timestamp header pulls the parser into sync
        if (st == ST_UNSYNC && (c == HDR_TARGET || is_local_ts(c) || is_global_ts(c)))
            st = ST_IDLE;
        case (st)
            ST_UNSYNC: begin
                r.byte_class = CLS_DROP;
                nxt = ST_UNSYNC;
            end
            ST_IDLE: begin
                if (c == HDR_TARGET) begin
                    r.byte_class = CLS_THDR;
                    nxt = ST_TARGET;
                end else if ((c & SIZE_MASK) != 8'h00) begin
                    r.byte_class = CLS_SHDR;
                    // Software sources carry an address in bits 7:3
                    if ((c & SW_HW_BIT) == 8'h00) begin
                        src_bit = 32'd1 << c[7:3];
                        r.new_unknown_source = (src_seen & src_bit) == '0;
                        src_seen = src_seen | src_bit;
                    end
                    case (c[1:0])
                        SIZE_ONE: nxt = ST_SKIP1;
                        SIZE_TWO: nxt = ST_SKIP2;
                        default:  nxt = ST_SKIP4;
                    endcase
                end else if (is_local_ts(c) || is_global_ts(c)) begin
                    r.byte_class = CLS_TIME;
                    ts_cnt = ts_cnt + 32'd1;
                    nxt = after_hdr(c);
                end else if ((c & EXT_MASK) == EXT_VALUE) begin
                    r.byte_class = CLS_EXT;
                    nxt = after_hdr(c);
                end else begin
                    // Unknown header; overflow lands here and counts twice
                    r.byte_class = CLS_ERROR;
                    if (c == HDR_OVERFLOW)
                        ovf_cnt = ovf_cnt + 32'd1;
                    r.new_unknown_opcode = !opcode_seen[c];
                    opcode_seen[c] = 1'b1;
                    err_cnt = err_cnt + 32'd1;
                    nxt = after_hdr(c);
                end
            end
            ST_TARGET: begin
                r.byte_class = CLS_TDATA;
                r.target_valid = 1'b1;
                r.target_byte = c;
                tdata_cnt = tdata_cnt + 32'd1;
            end
            ST_CONT: begin
                r.byte_class = CLS_CONT;
                nxt = after_hdr(c);
            end
            ST_SKIP4: begin
                r.byte_class = CLS_PAYLOAD;
                nxt = ST_SKIP3;
            end
            ST_SKIP3: begin
                r.byte_class = CLS_PAYLOAD;
                nxt = ST_SKIP2;
            end
            ST_SKIP2: begin
                r.byte_class = CLS_PAYLOAD;
                nxt = ST_SKIP1;
            end
            default: begin
                r.byte_class = CLS_PAYLOAD;
            end
        endcase
        parse_st = nxt;
        r.raw_byte_count = raw_cnt;
        r.target_data_count = tdata_cnt;
        r.time_packet_count = ts_cnt;
        r.overflow_count = ovf_cnt;
        r.error_count = err_cnt;
        r.source_mask = src_seen;
        r.in_sync = (nxt != ST_UNSYNC);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Result channel: receiver stalls and the scoreboard
    // ------------------------------------------------------------------------

    // Drop m_ready at random on the falling edge, at the current idle rate
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    function automatic void check_field(input string fname, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
            mismatches++;
        end
    endfunction

    // Sample each accepted result beat on the rising edge and match it
    // against the oldest prediction
    always @(posedge aclk) begin : scoreboard
        itm_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (decoded_beats.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, got %p",
                         $time, m_data);
                mismatches++;
            end else begin
                want = decoded_beats.pop_front();
                check_field("target_valid", 32'(want.target_valid),
                            32'(m_data.target_valid));
                check_field("target_byte", 32'(want.target_byte),
                            32'(m_data.target_byte));
                check_field("byte_class", 32'(want.byte_class), 32'(m_data.byte_class));
                check_field("new_unknown_opcode", 32'(want.new_unknown_opcode),
                            32'(m_data.new_unknown_opcode));
                check_field("new_unknown_source", 32'(want.new_unknown_source),
                            32'(m_data.new_unknown_source));
                check_field("raw_byte_count", want.raw_byte_count, m_data.raw_byte_count);
                check_field("target_data_count", want.target_data_count,
                            m_data.target_data_count);
                check_field("time_packet_count", want.time_packet_count,
                            m_data.time_packet_count);
                check_field("overflow_count", want.overflow_count, m_data.overflow_count);
                check_field("error_count", want.error_count, m_data.error_count);
                check_field("source_mask", want.source_mask, m_data.source_mask);
                check_field("in_sync", 32'(want.in_sync), 32'(m_data.in_sync));
            end
        end
    end

    // Watchdog: count cycles in which neither channel moves a beat
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Input channel
    // ------------------------------------------------------------------------

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    // Send one trace byte. Insert random idle cycles first, then hold valid
    // and the payload until the beat is taken. Predict its result on the
    // accepting edge. Return on the next falling edge.
    task automatic send_byte(input logic [7:0] b, input logic rs);
        itm_out_t dec;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= {b, rs};
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        dec = decode_trace_byte(b, rs);
        decoded_beats.push_back(dec);
        if (dec.byte_class != CLS_DROP)
            parsed_beats++;
        @(negedge aclk);
    endtask

    // Hold the sender off until every predicted result has been seen
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (decoded_beats.size() != 0)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Follow a header with bit 7 set by 0..3 continuation bytes and a closer
    task automatic send_cont_tail(input logic [7:0] hdr);
        int n;
        if ((hdr & CONT_BIT) != 8'h00) begin
            n = $urandom_range(0, 3);
            repeat (n) send_byte(rand_byte() | CONT_BIT, 1'b0);
            send_byte(rand_byte() & ~CONT_BIT, 1'b0);
        end
    endtask

    // One random packet: mostly well-formed, with some noise, host-side
    // resyncs, and source packets cut short
    task automatic send_random_packet();
        int          pick;
        int          n;
        logic [7:0]  hdr;
        logic [2:0]  ts_bits;
        logic [7:0]  err_picks [3];
        pick = $urandom_range(0, 99);
        err_picks = '{8'h00, HDR_OVERFLOW, CONT_BIT};
        if (pick < 8) begin
            send_byte(rand_byte(), 1'b0);
        end else if (pick < 13) begin
            send_byte(rand_byte(), 1'b1);
        end else if (pick < 17) begin
            // Start a four-byte source packet, then resync in its payload
            send_byte({5'($urandom), 1'($urandom), 2'b11}, 1'b0);
            repeat ($urandom_range(1, 3)) send_byte(rand_byte(), 1'b0);
            send_byte(HDR_TARGET, 1'b1);
        end else begin
            case ($urandom_range(0, 6))
                0: begin
                    send_byte(HDR_TARGET, 1'b0);
                    send_byte(rand_byte(), 1'b0);
                end
                1, 2: begin
                    // Software or hardware source, random size code
                    hdr = {5'($urandom), 1'($urandom), 2'($urandom_range(1, 3))};
                    send_byte(hdr, 1'b0);
                    n = (hdr[1:0] == SIZE_ONE) ? 1 : (hdr[1:0] == SIZE_TWO) ? 2 : 4;
                    repeat (n) send_byte(rand_byte(), 1'b0);
                end
                3: begin
                    // Local timestamp; skip 0x70, which is the overflow byte
                    ts_bits = 3'($urandom_range(1, 7));
                    hdr = {(ts_bits == 3'd7) ? 1'b1 : 1'($urandom), ts_bits, 4'h0};
                    send_byte(hdr, 1'b0);
                    send_cont_tail(hdr);
                end
                4: begin
                    hdr = GTS_VALUE | {2'b00, 1'($urandom), 5'b0};
                    send_byte(hdr, 1'b0);
                    send_cont_tail(hdr);
                end
                5: begin
                    hdr = (rand_byte() & ~EXT_MASK) | EXT_VALUE;
                    send_byte(hdr, 1'b0);
                    send_cont_tail(hdr);
                end
                default: begin
                    // Unknown header: zero, overflow, bare bit 7, or low nibble 4
                    if ($urandom_range(0, 2) == 0) begin
                        hdr = err_picks[$urandom_range(0, 2)];
                    end else begin
                        hdr = (rand_byte() & 8'hf0) | 8'h04;
                        if ((hdr & GTS_MASK) == GTS_VALUE)
                            hdr = hdr ^ 8'h40;
                    end
                    send_byte(hdr, 1'b0);
                    send_cont_tail(hdr);
                end
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Out of reset: drop zero, overflow and junk, then sync on a target
    // header and take an all-ones data byte
    task automatic test_unsynced_drop();
        logic [7:0] seq [5];
        seq = '{8'h00, HDR_OVERFLOW, 8'hff, HDR_TARGET, 8'hff};
        foreach (seq[i]) send_byte(seq[i], 1'b0);
    endtask

    // Every header class while in sync: zero and overflow errors, software
    // source at the top address with size one, hardware source with size
    // four, local timestamp with continuation, global timestamp (its bit 7
    // opens a continuation, which the extension byte then closes), error
    // with bit 7 followed by a continuation byte
    task automatic test_header_classes();
        logic [7:0] seq [17];
        seq = '{8'h00, HDR_OVERFLOW, 8'hf9, 8'haa, 8'h07, 8'h11, 8'h22, 8'h33, 8'h44,
                8'hc0, 8'h80, 8'h7f, GTS_VALUE, EXT_VALUE, HDR_OVERFLOW, CONT_BIT,
                8'h00};
        foreach (seq[i]) send_byte(seq[i], 1'b0);
    endtask

    // Resync in the middle of a skip: the payload phase is abandoned, the
    // next byte is dropped, and a global timestamp brings sync back
    task automatic test_resync_abandon();
        send_byte(8'h02, 1'b0);
        send_byte(8'h5a, 1'b0);
        send_byte(8'h5a, 1'b1);
        send_byte(8'hb4, 1'b0);
        send_byte(8'h00, 1'b0);
        wait_for_results();
    endtask

    // Random packet stream until about n bytes have been parsed in sync
    task automatic test_random_stream(input int n);
        int start;
        start = parsed_beats;
        while (parsed_beats - start < n)
            send_random_packet();
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        // Hold reset, then release it on a falling edge
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Sparse sender, heavily stalled receiver
        send_idle_pct = 33;
        recv_idle_pct = 84;
        test_unsynced_drop();
        test_header_classes();
        test_resync_abandon();
        test_random_stream(115);

        // Bursty receiver, slow sender
        send_idle_pct = 84;
        recv_idle_pct = 33;
        test_random_stream(115);

        // Full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(120);

        // Let any stray result beat show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
